// File: src/dwpi_pkg.sv
package dwpi_pkg;

   typedef enum logic [2:0] {
      ACT_PUSH     = 3'd0,
      ACT_POP_HEAD = 3'd1,
      ACT_POP_TAIL = 3'd2,
      ACT_INSERT   = 3'd3,
      ACT_CLEAR    = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_POP,
      S_SHIFT,
      S_FINAL
   } state_type;

   localparam int BEHIND_WIDTH = 4;
   localparam logic [BEHIND_WIDTH-1:0] BEHIND_RESET = 4'd3;

endpackage

// File: src/deque_with_priority_insert.sv
// Bounded double-ended queue held in one synchronous memory, serving one request at a
// time. A request is taken when start is high and busy is low. Push, clear, unused
// actions and refused requests (pop on empty, insert on full) give their response in
// the cycle after the request and leave busy low, so one such request can be taken
// every cycle. A pop reads the memory first: busy is high for one cycle, and the S_POP
// state then gives the response. A priority insert that has to move n entries
// (n = min(behind_count, occupancy)) copies them one per cycle through the memory's
// read and write ports in the S_SHIFT state, then writes the new entry in S_FINAL,
// which gives the response; with n = 0 it behaves like a push. The response is shown
// for exactly one cycle with rsp_strobe high and cannot be held off by the receiver.
module deque_with_priority_insert #(
   parameter int DEPTH    = 16,
   parameter int ID_WIDTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [2:0]                          req_action,
   input  logic [ID_WIDTH-1:0]                 req_entry_id,
   input  logic                                req_entry_urgent,
   input  logic                                csr_write_enable,
   input  logic [dwpi_pkg::BEHIND_WIDTH-1:0]   csr_write_data,
   output logic                                rsp_strobe,
   output logic                                rsp_out_valid,
   output logic [ID_WIDTH-1:0]                 rsp_out_id,
   output logic                                rsp_out_urgent,
   output logic [1:0]                          rsp_status,
   output logic [$clog2(DEPTH+1)-1:0]          rsp_occupancy,
   output logic                                rsp_is_empty
);
   import dwpi_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (CW > BEHIND_WIDTH) ? CW : BEHIND_WIDTH;
   localparam int MW = ID_WIDTH + 1;

   logic [MW-1:0] entry_mem_ff [DEPTH];
   logic [MW-1:0] mem_rdata_ff;
   logic          mem_we;
   logic [PW-1:0] mem_waddr;
   logic [MW-1:0] mem_wdata;
   logic          mem_re;
   logic [PW-1:0] mem_raddr;

   state_type              state_ff, state_in;
   logic [PW-1:0]          head_ff, head_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [PW-1:0]          cur_ff, cur_in;
   logic [PW-1:0]          pos_ff, pos_in;
   logic [ID_WIDTH-1:0]    new_id_ff, new_id_in;
   logic                   new_urg_ff, new_urg_in;
   logic [BEHIND_WIDTH-1:0] behind_ff;

   logic                   rsp_strobe_ff, rsp_strobe_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ID_WIDTH-1:0]    rsp_id_ff, rsp_id_in;
   logic                   rsp_urg_ff, rsp_urg_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [CW-1:0]          rsp_occ_ff, rsp_occ_in;
   logic                   rsp_empty_ff, rsp_empty_in;

   logic          full;
   logic          empty;
   logic [PW-1:0] cnt_off;
   logic [PW-1:0] cnt_m1;
   logic [XW-1:0] cnt_x;
   logic [XW-1:0] beh_x;
   logic [XW-1:0] pos_x;
   logic [PW-1:0] ins_pos;

   function automatic logic [PW-1:0] slot(input logic [PW-1:0] base,
                                          input logic [PW-1:0] off);
      logic [PW:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= (PW+1)'(DEPTH)) begin
         sum = sum - (PW+1)'(DEPTH);
      end
      return sum[PW-1:0];
   endfunction

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign cnt_off = PW'(count_ff);
   assign cnt_m1  = PW'(count_ff - CW'(1));
   assign cnt_x   = XW'(count_ff);
   assign beh_x   = XW'(behind_ff);
   assign pos_x   = (cnt_x > beh_x) ? (cnt_x - beh_x) : '0;
   assign ins_pos = PW'(pos_x);

   assign busy = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= entry_mem_ff[mem_raddr];
      end
   end

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      cur_in        = cur_ff;
      pos_in        = pos_ff;
      new_id_in     = new_id_ff;
      new_urg_in    = new_urg_ff;
      rsp_strobe_in = 1'b0;
      rsp_valid_in  = rsp_valid_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_urg_in    = rsp_urg_ff;
      rsp_status_in = rsp_status_ff;
      rsp_occ_in    = rsp_occ_ff;
      mem_we        = 1'b0;
      mem_waddr     = slot(head_ff, cnt_off);
      mem_wdata     = {req_entry_urgent, req_entry_id};
      mem_re        = 1'b0;
      mem_raddr     = slot(head_ff, cnt_m1);
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               new_id_in     = req_entry_id;
               new_urg_in    = req_entry_urgent;
               rsp_valid_in  = 1'b0;
               rsp_id_in     = '0;
               rsp_urg_in    = 1'b0;
               rsp_status_in = STATUS_OK;
               case (req_action)
                  ACT_PUSH, ACT_INSERT: begin
                     if (full) begin
                        rsp_status_in = STATUS_FULL;
                        rsp_strobe_in = 1'b1;
                     end else if (req_action == ACT_PUSH || ins_pos == cnt_off) begin
                        mem_we        = 1'b1;
                        count_in      = count_ff + CW'(1);
                        rsp_strobe_in = 1'b1;
                     end else begin
                        mem_re   = 1'b1;
                        cur_in   = cnt_m1;
                        pos_in   = ins_pos;
                        count_in = count_ff + CW'(1);
                        state_in = S_SHIFT;
                     end
                  end
                  ACT_POP_HEAD, ACT_POP_TAIL: begin
                     if (empty) begin
                        rsp_status_in = STATUS_EMPTY;
                        rsp_strobe_in = 1'b1;
                     end else begin
                        mem_re = 1'b1;
                        if (req_action == ACT_POP_HEAD) begin
                           mem_raddr = head_ff;
                           head_in   = slot(head_ff, PW'(1));
                        end
                        count_in = count_ff - CW'(1);
                        state_in = S_POP;
                     end
                  end
                  ACT_CLEAR: begin
                     count_in      = '0;
                     head_in       = '0;
                     rsp_strobe_in = 1'b1;
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
               rsp_occ_in = count_in;
            end
         end
         S_POP: begin
            rsp_valid_in  = 1'b1;
            rsp_id_in     = mem_rdata_ff[ID_WIDTH-1:0];
            rsp_urg_in    = mem_rdata_ff[ID_WIDTH];
            rsp_occ_in    = count_ff;
            rsp_strobe_in = 1'b1;
            state_in      = S_IDLE;
         end
         S_SHIFT: begin
            mem_we    = 1'b1;
            mem_waddr = slot(head_ff, cur_ff + PW'(1));
            mem_wdata = mem_rdata_ff;
            if (cur_ff == pos_ff) begin
               state_in = S_FINAL;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = slot(head_ff, cur_ff - PW'(1));
               cur_in    = cur_ff - PW'(1);
            end
         end
         S_FINAL: begin
            mem_we        = 1'b1;
            mem_waddr     = slot(head_ff, pos_ff);
            mem_wdata     = {new_urg_ff, new_id_ff};
            rsp_occ_in    = count_ff;
            rsp_strobe_in = 1'b1;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_empty_in = (rsp_occ_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         head_ff       <= '0;
         count_ff      <= '0;
         behind_ff     <= BEHIND_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_write_enable) begin
            behind_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      pos_ff        <= pos_in;
      new_id_ff     <= new_id_in;
      new_urg_ff    <= new_urg_in;
      rsp_valid_ff  <= rsp_valid_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_urg_ff    <= rsp_urg_in;
      rsp_status_ff <= rsp_status_in;
      rsp_occ_ff    <= rsp_occ_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_out_valid  = rsp_valid_ff;
   assign rsp_out_id     = rsp_id_ff;
   assign rsp_out_urgent = rsp_urg_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_occupancy  = rsp_occ_ff;
   assign rsp_is_empty   = rsp_empty_ff;

endmodule

// File: src/dwpi_checker.sv
module dwpi_checker #(
   parameter int OCC_WIDTH = 5
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic [2:0]           req_action,
   input logic                 rsp_strobe,
   input logic                 rsp_out_valid,
   input logic [1:0]           rsp_status,
   input logic [OCC_WIDTH-1:0] rsp_occupancy,
   input logic                 rsp_is_empty
);
   import dwpi_pkg::*;

   // no response while a request is still at work
   assert property (@(posedge clock) disable iff (reset) busy |-> !rsp_strobe)
      else $error("response shown while busy");

   // a clear request answers next cycle with an empty queue
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_action == ACT_CLEAR)
         |=> (rsp_strobe && rsp_is_empty && rsp_status == STATUS_OK))
      else $error("clear did not empty the queue");

   // a popped entry only comes with an ok status
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_out_valid) |-> (rsp_status == STATUS_OK))
      else $error("popped entry with error status");

   // a pop on empty leaves the queue empty
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == STATUS_EMPTY) |-> (!rsp_out_valid && rsp_occupancy == '0))
      else $error("pop on empty reported a non-empty queue");

   // empty flag agrees with occupancy
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_is_empty == (rsp_occupancy == '0)))
      else $error("empty flag disagrees with occupancy");

endmodule

bind deque_with_priority_insert dwpi_checker #(
   .OCC_WIDTH($clog2(DEPTH + 1))
) u_dwpi_checker (.*);

// File: sim/deque_with_priority_insert_test.sv
module deque_with_priority_insert_test;
   timeunit 1ns;
   timeprecision 1ps;

   import dwpi_pkg::*;

   localparam int DEPTH = 16;
   localparam int ID_WIDTH = 16;
   localparam int OCC_WIDTH = $clog2(DEPTH + 1);
   localparam int CYCLE_LIMIT = 500000;
   localparam int PRINT_LIMIT = 40;
   localparam int PHASES = 10;
   localparam int PHASE_ITEMS = 170;
   localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
   localparam logic [2:0] ACT_SPARE_LAST = 3'd7;

   typedef struct packed {
      logic [2:0]          action;
      logic [ID_WIDTH-1:0] id;
      logic                urgent;
   } deque_request_type;

   typedef struct packed {
      logic                 valid;
      logic [ID_WIDTH-1:0]  id;
      logic                 urgent;
      status_type           status;
      logic [OCC_WIDTH-1:0] occupancy;
      logic                 is_empty;
   } deque_response_type;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic [2:0] req_action;
   logic [ID_WIDTH-1:0] req_entry_id;
   logic req_entry_urgent;
   logic csr_write_enable;
   logic [BEHIND_WIDTH-1:0] csr_write_data;
   logic rsp_strobe;
   logic rsp_out_valid;
   logic [ID_WIDTH-1:0] rsp_out_id;
   logic rsp_out_urgent;
   logic [1:0] rsp_status;
   logic [OCC_WIDTH-1:0] rsp_occupancy;
   logic rsp_is_empty;

   deque_with_priority_insert #(
      .DEPTH(DEPTH),
      .ID_WIDTH(ID_WIDTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_action(req_action),
      .req_entry_id(req_entry_id),
      .req_entry_urgent(req_entry_urgent),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .rsp_strobe(rsp_strobe),
      .rsp_out_valid(rsp_out_valid),
      .rsp_out_id(rsp_out_id),
      .rsp_out_urgent(rsp_out_urgent),
      .rsp_status(rsp_status),
      .rsp_occupancy(rsp_occupancy),
      .rsp_is_empty(rsp_is_empty)
   );

   // deque image and insert depth
   logic [ID_WIDTH-1:0] model_ids [DEPTH];
   logic model_urgent [DEPTH];
   int model_head;
   int model_count;
   logic [BEHIND_WIDTH-1:0] insert_depth;

   deque_request_type pending_requests [$];
   deque_response_type expected_responses [$];
   deque_request_type next_request;

   int issued_count;
   int answered_count;
   int mismatch_count;
   int gap_left;
   bit no_idle;
   bit request_taken;
   int cycle_count;
   int popped_count;
   int full_count;
   int empty_count;
   int config_count;
   int peak_occupancy;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic apply_request(input deque_request_type r, output deque_response_type e);
      int pos;
      int i;
      int s;
      e = '0;
      e.status = STATUS_OK;
      if (r.action == ACT_PUSH || r.action == ACT_INSERT) begin
         if (model_count >= DEPTH) begin
            e.status = STATUS_FULL;
         end else begin
            pos = model_count;
            if (r.action == ACT_INSERT) begin
               pos = (model_count > insert_depth) ? model_count - insert_depth : 0;
            end
            for (i = model_count; i > pos; i--) begin
               model_ids[(model_head + i) % DEPTH] = model_ids[(model_head + i - 1) % DEPTH];
               model_urgent[(model_head + i) % DEPTH] =
                  model_urgent[(model_head + i - 1) % DEPTH];
            end
            model_ids[(model_head + pos) % DEPTH] = r.id;
            model_urgent[(model_head + pos) % DEPTH] = r.urgent;
            model_count++;
         end
      end else if (r.action == ACT_POP_HEAD || r.action == ACT_POP_TAIL) begin
         if (model_count == 0) begin
            e.status = STATUS_EMPTY;
         end else begin
            s = (r.action == ACT_POP_HEAD) ? model_head : (model_head + model_count - 1) % DEPTH;
            e.valid = 1'b1;
            e.id = model_ids[s];
            e.urgent = model_urgent[s];
            if (r.action == ACT_POP_HEAD) begin
               model_head = (model_head + 1) % DEPTH;
            end
            model_count--;
         end
      end else if (r.action == ACT_CLEAR) begin
         model_count = 0;
         model_head = 0;
      end
      e.occupancy = OCC_WIDTH'(model_count);
      e.is_empty = (model_count == 0);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= PRINT_LIMIT) begin
            $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
         end
      end
   endtask

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_idle || roll < 60) begin
         return 0;
      end else if (roll < 90) begin
         return $urandom_range(1, 3);
      end else begin
         return $urandom_range(8, 40);
      end
   endfunction

   // monitor: response check, then request capture into the deque image
   always @(posedge clock) begin
      deque_response_type want;
      deque_request_type seen;
      request_taken = 1'b0;
      if (reset) begin
         model_head = 0;
         model_count = 0;
         insert_depth = BEHIND_RESET;
      end else begin
         if (rsp_strobe) begin
            if (expected_responses.size() == 0) begin
               mismatch_count++;
               $display("%0t ns: response with no request outstanding, expected none, got id %0h",
                        $time, rsp_out_id);
            end else begin
               want = expected_responses.pop_front();
               answered_count++;
               check_field("out_valid", 32'(want.valid), 32'(rsp_out_valid));
               check_field("out_id", 32'(want.id), 32'(rsp_out_id));
               check_field("out_urgent", 32'(want.urgent), 32'(rsp_out_urgent));
               check_field("status", 32'(want.status), 32'(rsp_status));
               check_field("occupancy", 32'(want.occupancy), 32'(rsp_occupancy));
               check_field("is_empty", 32'(want.is_empty), 32'(rsp_is_empty));
               if (want.valid) popped_count++;
               if (want.status == STATUS_FULL) full_count++;
               if (want.status == STATUS_EMPTY) empty_count++;
            end
         end
         if (csr_write_enable) begin
            insert_depth = csr_write_data;
         end
         if (start && !busy) begin
            seen.action = req_action;
            seen.id = req_entry_id;
            seen.urgent = req_entry_urgent;
            apply_request(seen, want);
            expected_responses.push_back(want);
            if (model_count > peak_occupancy) peak_occupancy = model_count;
            request_taken = 1'b1;
         end
      end
   end

   // driver
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || request_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_requests.size() != 0) begin
            next_request = pending_requests.pop_front();
            start <= 1'b1;
            req_action <= next_request.action;
            req_entry_id <= next_request.id;
            req_entry_urgent <= next_request.urgent;
            gap_left = pick_gap();
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic queue_request(input logic [2:0] action, input logic [ID_WIDTH-1:0] id,
                                input logic urgent);
      deque_request_type r;
      r.action = action;
      r.id = id;
      r.urgent = urgent;
      pending_requests.push_back(r);
      issued_count++;
   endtask

   task automatic wait_drained();
      while (answered_count != issued_count) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_insert_depth(input logic [BEHIND_WIDTH-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      config_count++;
   endtask

   task automatic queue_random_phase(input int count, input int grow_share);
      int made;
      int roll;
      logic [2:0] act;
      logic [ID_WIDTH-1:0] id;
      made = 0;
      while (made < count) begin
         roll = $urandom_range(0, 999);
         if (roll < grow_share / 2) begin
            act = ACT_PUSH;
         end else if (roll < grow_share) begin
            act = ACT_INSERT;
         end else if (roll < 980) begin
            act = $urandom_range(0, 1) ? ACT_POP_HEAD : ACT_POP_TAIL;
         end else if (roll < 990) begin
            act = ACT_CLEAR;
         end else begin
            act = 3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
         end
         if ($urandom_range(0, 9) == 0) begin
            id = $urandom_range(0, 1) ? '1 : '0;
         end else begin
            id = ID_WIDTH'($urandom_range(0, (1 << ID_WIDTH) - 1));
         end
         queue_request(act, id, 1'($urandom_range(0, 1)));
         if (act <= ACT_CLEAR) made++;
      end
   endtask

   initial begin
      logic [BEHIND_WIDTH-1:0] depth_plan [PHASES];
      int a;
      int p;
      depth_plan = '{4'd15, 4'd0, 4'd1, 4'd15, 4'd0, 4'd7, 4'd2, 4'd0, 4'd14, 4'd15};
      reset = 1'b1;
      start = 1'b0;
      req_action = ACT_PUSH;
      req_entry_id = '0;
      req_entry_urgent = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      gap_left = 0;
      no_idle = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed, insert depth at its reset value
      @(posedge clock);
      queue_request(ACT_POP_HEAD, '0, 1'b0);
      queue_request(ACT_POP_TAIL, '0, 1'b0);
      queue_request(ACT_INSERT, 16'h1234, 1'b1);
      queue_request(ACT_PUSH, '1, 1'b1);
      queue_request(ACT_PUSH, '0, 1'b0);
      queue_request(ACT_PUSH, 16'hA5A5, 1'b0);
      queue_request(ACT_INSERT, 16'h5A5A, 1'b1);
      for (a = ACT_SPARE_FIRST; a <= ACT_SPARE_LAST; a++) begin
         queue_request(3'(a), '1, 1'b1);
      end
      queue_request(ACT_POP_HEAD, '0, 1'b0);
      queue_request(ACT_POP_TAIL, '0, 1'b0);
      queue_request(ACT_POP_HEAD, '0, 1'b0);
      queue_request(ACT_POP_TAIL, '0, 1'b0);
      queue_request(ACT_POP_HEAD, '0, 1'b0);
      queue_request(ACT_POP_HEAD, '1, 1'b1);
      queue_request(ACT_PUSH, 16'h00FF, 1'b1);
      queue_request(ACT_CLEAR, '0, 1'b0);
      queue_request(ACT_POP_TAIL, '0, 1'b0);
      queue_request(ACT_PUSH, '1, 1'b1);
      queue_request(ACT_INSERT, '0, 1'b0);
      queue_request(ACT_POP_TAIL, '0, 1'b0);
      queue_request(ACT_POP_HEAD, '0, 1'b0);
      wait_drained();

      for (p = 0; p < PHASES; p++) begin
         write_insert_depth((p == 5 || p == 7) ?
                            BEHIND_WIDTH'($urandom_range(0, DEPTH - 1)) : depth_plan[p]);
         no_idle = (p % 4 == 3);
         @(posedge clock);
         queue_random_phase(PHASE_ITEMS, (p % 3 == 0) ? 750 : ((p % 3 == 1) ? 250 : 500));
         wait_drained();
      end

      repeat (20) @(negedge clock);
      $display("%0d requests answered across %0d insert depth settings, %0d entries popped",
               answered_count, config_count, popped_count);
      $display("%0d full refusals, %0d pops on empty, peak occupancy %0d",
               full_count, empty_count, peak_occupancy);
      if (mismatch_count == 0 && expected_responses.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// File: files.f
src/dwpi_pkg.sv
src/deque_with_priority_insert.sv
src/dwpi_checker.sv
sim/deque_with_priority_insert_test.sv
